[hdl/stq_pkg.sv]
// Shared types and constants of the sorted timer queue.
// Used by stq_ctrl, stq_datapath and sorted_timer_queue_core; depends on nothing.
`default_nettype none
package stq_pkg;

    localparam int NUM_TIMERS = 16;

    localparam int TIME_W    = 32;
    localparam int EVENT_W   = 16;
    localparam int ID_W      = 4;
    localparam int OWNER_W   = 3;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    // Request payload layout, lowest bit first.
    localparam int IN_ID_LO    = 0;
    localparam int IN_OWN_LO   = IN_ID_LO + ID_W;
    localparam int IN_ALARM_LO = IN_OWN_LO + OWNER_W;
    localparam int IN_PER_LO   = IN_ALARM_LO + TIME_W;
    localparam int IN_REP_BIT  = IN_PER_LO + TIME_W;
    localparam int IN_SEND_BIT = IN_REP_BIT + 1;
    localparam int IN_EV_LO    = IN_SEND_BIT + 1;
    localparam int IN_NOW_LO   = IN_EV_LO + EVENT_W;
    localparam int IN_DATA_W   = 128;

    // Result payload layout, lowest bit first.
    localparam int OUT_HEAD_LO  = STATUS_W;
    localparam int OUT_ALARM_LO = OUT_HEAD_LO + ID_W;
    localparam int OUT_EVV_BIT  = OUT_ALARM_LO + TIME_W;
    localparam int OUT_EVO_LO   = OUT_EVV_BIT + 1;
    localparam int OUT_EVD_LO   = OUT_EVO_LO + OWNER_W;
    localparam int OUT_CNT_LO   = OUT_EVD_LO + EVENT_W;
    localparam int OUT_DATA_W   = 64;

    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_EXPIRE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CANCEL = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CANOWN = 3'd4;
    localparam logic [FUNC_W-1:0] FN_TAKE   = 3'd5;

    localparam logic [STATUS_W-1:0] SC_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] SC_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] SC_NOTQUEUE = 2'd2;
    localparam logic [STATUS_W-1:0] SC_NOFREE   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INSERT,
        S_OWNER,
        S_FIN
    } t_state;

    typedef struct packed {
        logic                load;
        logic                remove_id;
        logic                write_rec;
        logic                ld_alarm;
        logic                reload;
        logic                insert;
        logic                pop;
        logic                owner_step;
        logic                push_req;
        logic                take;
        logic                cap_event;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                emit;
    } t_dp_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              id_ok;
        logic              found;
        logic              repeat_on;
        logic              agent;
        logic              q_empty;
        logic              f_empty;
        logic              owner_hit;
        logic              out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

[hdl/stq_ctrl.sv]
// Sequencer of the sorted timer queue: walks each request through its steps.
// Depends on stq_pkg; drives stq_datapath through command and status structs.
`default_nettype none
module stq_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  stq_pkg::t_dp_stat   i_stat,
    output stq_pkg::t_dp_cmd    o_cmd
);

    stq_pkg::t_state r_state;
    stq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = stq_pkg::S_EXEC;
            end
            stq_pkg::S_EXEC: begin
                n_state = stq_pkg::S_FIN;
                case (i_stat.func)
                    stq_pkg::FN_INSERT: begin
                        if (i_stat.id_ok) n_state = stq_pkg::S_INSERT;
                    end
                    stq_pkg::FN_EXPIRE: begin
                        if (i_stat.id_ok && i_stat.repeat_on) n_state = stq_pkg::S_INSERT;
                    end
                    stq_pkg::FN_CANOWN: n_state = stq_pkg::S_OWNER;
                    default: n_state = stq_pkg::S_FIN;
                endcase
            end
            stq_pkg::S_INSERT: n_state = stq_pkg::S_FIN;
            stq_pkg::S_OWNER: begin
                if (!i_stat.owner_hit) n_state = stq_pkg::S_FIN;
            end
            stq_pkg::S_FIN: begin
                if (i_stat.out_free) n_state = stq_pkg::S_IDLE;
            end
            default: n_state = stq_pkg::S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            stq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            stq_pkg::S_EXEC: begin
                unique case (i_stat.func)
                    stq_pkg::FN_INSERT: begin
                        if (!i_stat.id_ok) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = stq_pkg::SC_NOTQUEUE;
                        end else begin
                            o_cmd.remove_id = 1'b1;
                            o_cmd.write_rec = 1'b1;
                            o_cmd.ld_alarm  = 1'b1;
                        end
                    end
                    stq_pkg::FN_POP: begin
                        if (i_stat.q_empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = stq_pkg::SC_EMPTY;
                        end else begin
                            o_cmd.pop = 1'b1;
                        end
                    end
                    stq_pkg::FN_EXPIRE: begin
                        if (!i_stat.id_ok) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = stq_pkg::SC_NOTQUEUE;
                        end else begin
                            o_cmd.remove_id = 1'b1;
                            o_cmd.cap_event = 1'b1;
                            o_cmd.ld_alarm  = i_stat.repeat_on;
                            o_cmd.reload    = 1'b1;
                            o_cmd.push_req  = !i_stat.repeat_on && i_stat.agent;
                        end
                    end
                    stq_pkg::FN_CANCEL: begin
                        if (!i_stat.id_ok || !i_stat.found) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = stq_pkg::SC_NOTQUEUE;
                        end else begin
                            o_cmd.remove_id = 1'b1;
                            o_cmd.push_req  = 1'b1;
                        end
                    end
                    stq_pkg::FN_TAKE: begin
                        if (i_stat.f_empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = stq_pkg::SC_NOFREE;
                        end else begin
                            o_cmd.take = 1'b1;
                        end
                    end
                    default: o_cmd.set_status = 1'b0;
                endcase
            end
            stq_pkg::S_INSERT: o_cmd.insert = 1'b1;
            stq_pkg::S_OWNER:  o_cmd.owner_step = i_stat.owner_hit;
            stq_pkg::S_FIN:    o_cmd.emit = i_stat.out_free;
            default:           o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[hdl/stq_datapath.sv]
// Datapath of the sorted timer queue: ordered queue, timer records, free stack, result.
// Depends on stq_pkg; commanded by stq_ctrl.
`default_nettype none
module stq_datapath #(
    parameter int NUM_TASKS  = 8
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  stq_pkg::t_dp_cmd                  i_cmd,
    output stq_pkg::t_dp_stat                 o_stat,
    input  wire [stq_pkg::IN_DATA_W-1:0]      i_in_data,
    input  wire [stq_pkg::FUNC_W-1:0]         i_in_user,
    output logic                              o_out_valid,
    output logic [stq_pkg::OUT_DATA_W-1:0]    o_out_data,
    input  wire                               i_out_ready
);

    localparam int NUM_TIMERS = stq_pkg::NUM_TIMERS;
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int TW = stq_pkg::TIME_W;
    localparam int OW = stq_pkg::OWNER_W;
    localparam int EW = stq_pkg::EVENT_W;

    // Latched request.
    logic [stq_pkg::FUNC_W-1:0] r_func;
    logic [stq_pkg::ID_W-1:0]   r_id;
    logic [OW-1:0]              r_owner;
    logic [TW-1:0]              r_alarm, r_period, r_now;
    logic                       r_rep, r_send;
    logic [EW-1:0]              r_evbits;

    // Queue entries carry id, alarm and owner so that every compare is local.
    logic [IW-1:0] r_q_id    [NUM_TIMERS];
    logic [TW-1:0] r_q_alarm [NUM_TIMERS];
    logic [OW-1:0] r_q_owner [NUM_TIMERS];
    logic [CW-1:0] r_count;
    logic [IW-1:0] n_q_id    [NUM_TIMERS];
    logic [TW-1:0] n_q_alarm [NUM_TIMERS];
    logic [OW-1:0] n_q_owner [NUM_TIMERS];
    logic [CW-1:0] n_count;

    // Timer records. The expired mark and agent flag are not kept: neither is observable.
    logic [TW-1:0]         r_per [NUM_TIMERS];
    logic [OW-1:0]         r_own [NUM_TIMERS];
    logic [EW-1:0]         r_ev  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_frep, r_fsend;

    // Free stack of agent timers.
    logic [IW-1:0]         r_stack [NUM_TIMERS];
    logic [CW-1:0]         r_fcount;
    logic [NUM_TIMERS-1:0] r_mark;

    logic [TW-1:0] r_ins_alarm;

    // Result staging and output register.
    logic [stq_pkg::STATUS_W-1:0] r_res_status;
    logic [stq_pkg::ID_W-1:0]     r_res_head;
    logic [TW-1:0]                r_res_alarm;
    logic                         r_res_evv;
    logic [OW-1:0]                r_res_evo;
    logic [EW-1:0]                r_res_evd;
    logic                         r_out_valid;
    logic [stq_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [IW-1:0] rix;
    logic          id_ok;
    logic          rix_agent;
    logic [NUM_TIMERS-1:0] m_id, after_id, m_ow, after_ow, le, le_prev, shift_sel;
    logic          found, owner_hit;
    logic [IW-1:0] own_id;
    logic [IW-1:0] up_id    [NUM_TIMERS];
    logic [TW-1:0] up_alarm [NUM_TIMERS];
    logic [OW-1:0] up_owner [NUM_TIMERS];
    logic [IW-1:0] dn_id    [NUM_TIMERS];
    logic [TW-1:0] dn_alarm [NUM_TIMERS];
    logic [OW-1:0] dn_owner [NUM_TIMERS];
    logic [IW-1:0] push_id;
    logic          push_en;
    logic [CW-1:0] f_top;

    assign rix       = IW'(r_id);
    assign id_ok     = (32'(r_id) < 32'(NUM_TIMERS));
    assign rix_agent = (32'(rix) >= 32'(NUM_TASKS));
    assign f_top     = r_fcount - CW'(1);

    // Matches along the queue and their prefixes.
    always_comb begin
        logic acc_id, acc_ow;
        acc_id = 1'b0;
        acc_ow = 1'b0;
        own_id = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            m_id[i] = (CW'(i) < r_count) && (r_q_id[i] == rix);
            m_ow[i] = (CW'(i) < r_count) && (r_q_owner[i] == r_owner);
            le[i]   = (CW'(i) < r_count) && (r_q_alarm[i] <= r_ins_alarm);
            if (m_ow[i] && !acc_ow) own_id = r_q_id[i];
            acc_id      = acc_id | m_id[i];
            acc_ow      = acc_ow | m_ow[i];
            after_id[i] = acc_id;
            after_ow[i] = acc_ow;
        end
        found     = acc_id;
        owner_hit = acc_ow;
    end

    always_comb begin
        le_prev[0] = 1'b1;
        for (int i = 1; i < NUM_TIMERS; i++) le_prev[i] = le[i-1];
    end

    // Neighbour views for shifting up (removal) and down (insertion).
    always_comb begin
        for (int i = 0; i < NUM_TIMERS - 1; i++) begin
            up_id[i]    = r_q_id[i+1];
            up_alarm[i] = r_q_alarm[i+1];
            up_owner[i] = r_q_owner[i+1];
        end
        up_id[NUM_TIMERS-1]    = r_q_id[NUM_TIMERS-1];
        up_alarm[NUM_TIMERS-1] = r_q_alarm[NUM_TIMERS-1];
        up_owner[NUM_TIMERS-1] = r_q_owner[NUM_TIMERS-1];
        dn_id[0]    = r_q_id[0];
        dn_alarm[0] = r_q_alarm[0];
        dn_owner[0] = r_q_owner[0];
        for (int i = 1; i < NUM_TIMERS; i++) begin
            dn_id[i]    = r_q_id[i-1];
            dn_alarm[i] = r_q_alarm[i-1];
            dn_owner[i] = r_q_owner[i-1];
        end
    end

    always_comb begin
        if (i_cmd.pop) begin
            shift_sel = '1;
        end else if (i_cmd.owner_step) begin
            shift_sel = after_ow;
        end else begin
            shift_sel = after_id;
        end
    end

    // Queue next state: a removal closes the gap, an insertion opens one.
    always_comb begin
        n_q_id    = r_q_id;
        n_q_alarm = r_q_alarm;
        n_q_owner = r_q_owner;
        n_count   = r_count;
        if (i_cmd.pop || i_cmd.owner_step || (i_cmd.remove_id && found)) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (shift_sel[i]) begin
                    n_q_id[i]    = up_id[i];
                    n_q_alarm[i] = up_alarm[i];
                    n_q_owner[i] = up_owner[i];
                end
            end
            n_count = r_count - CW'(1);
        end else if (i_cmd.insert && (r_count < CW'(NUM_TIMERS))) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (le_prev[i] && !le[i]) begin
                    n_q_id[i]    = rix;
                    n_q_alarm[i] = r_ins_alarm;
                    n_q_owner[i] = r_own[rix];
                end else if (!le_prev[i]) begin
                    n_q_id[i]    = dn_id[i];
                    n_q_alarm[i] = dn_alarm[i];
                    n_q_owner[i] = dn_owner[i];
                end
            end
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_id    <= n_q_id;
        r_q_alarm <= n_q_alarm;
        r_q_owner <= n_q_owner;
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Request latch and insertion alarm.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_in_user;
            r_id     <= i_in_data[stq_pkg::IN_ID_LO +: stq_pkg::ID_W];
            r_owner  <= i_in_data[stq_pkg::IN_OWN_LO +: OW];
            r_alarm  <= i_in_data[stq_pkg::IN_ALARM_LO +: TW];
            r_period <= i_in_data[stq_pkg::IN_PER_LO +: TW];
            r_rep    <= i_in_data[stq_pkg::IN_REP_BIT];
            r_send   <= i_in_data[stq_pkg::IN_SEND_BIT];
            r_evbits <= i_in_data[stq_pkg::IN_EV_LO +: EW];
            r_now    <= i_in_data[stq_pkg::IN_NOW_LO +: TW];
        end
        if (i_cmd.ld_alarm) begin
            r_ins_alarm <= i_cmd.reload ? (r_now + r_per[rix]) : r_alarm;
        end
    end

    // Records.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_rec) begin
            r_per[rix] <= r_period;
            r_own[rix] <= r_owner;
            r_ev[rix]  <= r_evbits;
        end
        if (!i_rst_n) begin
            r_frep  <= '0;
            r_fsend <= '0;
        end else if (i_cmd.write_rec) begin
            r_frep[rix]  <= r_rep;
            r_fsend[rix] <= r_send;
        end
    end

    // Free stack: pushes skip task timers and timers already on the stack.
    assign push_id = i_cmd.owner_step ? own_id : rix;
    assign push_en = (i_cmd.push_req || i_cmd.owner_step)
                     && (32'(push_id) >= 32'(NUM_TASKS)) && !r_mark[push_id]
                     && (r_fcount < CW'(NUM_TIMERS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcount <= CW'(NUM_TIMERS - NUM_TASKS);
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_stack[k] <= (k < NUM_TIMERS - NUM_TASKS) ? IW'(NUM_TIMERS - 1 - k) : '0;
                r_mark[k]  <= (k >= NUM_TASKS);
            end
        end else if (push_en) begin
            r_stack[r_fcount[IW-1:0]] <= push_id;
            r_mark[push_id]           <= 1'b1;
            r_fcount                  <= r_fcount + CW'(1);
        end else if (i_cmd.take) begin
            r_mark[r_stack[f_top[IW-1:0]]] <= 1'b0;
            r_fcount                       <= f_top;
        end
    end

    // Result staging.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_status <= stq_pkg::SC_OK;
            r_res_head   <= '0;
            r_res_alarm  <= '0;
            r_res_evv    <= 1'b0;
            r_res_evo    <= '0;
            r_res_evd    <= '0;
        end else begin
            if (i_cmd.set_status) r_res_status <= i_cmd.status;
            if (i_cmd.pop) begin
                r_res_head  <= stq_pkg::ID_W'(r_q_id[0]);
                r_res_alarm <= r_q_alarm[0];
            end
            if (i_cmd.take) r_res_head <= stq_pkg::ID_W'(r_stack[f_top[IW-1:0]]);
            if (i_cmd.cap_event && rix_agent && r_fsend[rix]) begin
                r_res_evv <= 1'b1;
                r_res_evo <= r_own[rix];
                r_res_evd <= r_ev[rix];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_data <= {1'b0, stq_pkg::COUNT_W'(r_count), r_res_evd, r_res_evo,
                           r_res_evv, r_res_alarm, r_res_head, r_res_status};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_stat.func      = r_func;
        o_stat.id_ok     = id_ok;
        o_stat.found     = found;
        o_stat.repeat_on = r_frep[rix];
        o_stat.agent     = rix_agent;
        o_stat.q_empty   = (r_count == '0);
        o_stat.f_empty   = (r_fcount == '0);
        o_stat.owner_hit = owner_hit;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

endmodule
`default_nettype wire

[hdl/sorted_timer_queue_core.sv]
// Sorted timer queue: a bounded queue of timers ordered by alarm tick.
// Request channel (s_axis): tuser carries the operation code, tdata the timer fields.
// Result channel (m_axis): one result for every request, in request order.
// A request is taken only when the block is idle and is then worked through by the
// sequencer: an execute step, a sorted insertion step for insert and repeating expiry,
// an owner step for each cancelled timer plus a closing one for cancel by owner, and a
// final step that moves the result to the output register. A new request is accepted
// only after the last one has left the final step; the separate insertion step parts
// removal and sorted insertion.
// The output register parts the two sides: a new request is accepted while the last
// result still waits, and only the final hand-over of the next result waits for it.
// A stalled receiver therefore holds at most one finished result and one request.
// Synchronous active-low reset empties the queue, puts every agent timer back on the
// free stack and clears the repeat and send flags; timer records stay undefined until written.
// Results hold while tvalid is high and tready is low.
`default_nettype none
module sorted_timer_queue_core #(
    parameter int NUM_TASKS  = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: timer_id[3:0], owner_task[6:4], alarm_time[38:7], period[70:39],
    // repeat_req[71], send_event[72], event_bits[88:73], now_tick[120:89], zeros above.
    input  wire [stq_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // tuser: func[2:0].
    input  wire [stq_pkg::FUNC_W-1:0]        i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // tdata: status[1:0], head_id[5:2], head_alarm[37:6], event_valid[38],
    // event_owner[41:39], event_out[57:42], queued_count[62:58], zero at bit 63.
    output logic [stq_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    stq_pkg::t_dp_cmd  cmd;
    stq_pkg::t_dp_stat stat;

    // The sequencer decides each step from the latched operation and queue status.
    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds all timer state and the result register.
    stq_datapath #(
        .NUM_TASKS  (NUM_TASKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .i_out_ready (i_m_axis_tready)
    );

`ifndef SYNTHESIS
    // Only one request is in work at a time.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted while another is in work");

    // The queue never reports more timers than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[62:58] <= stq_pkg::NUM_TIMERS))
        else $error("queued count exceeds queue size");

    // An event only comes with a successful operation.
    a_event_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[38]) |-> (o_m_axis_tdata[1:0] == stq_pkg::SC_OK))
        else $error("event reported with an error status");
`endif

endmodule
`default_nettype wire

[tb/sorted_timer_queue_core_tb.sv]
// Testbench for the sorted timer queue core: drives timer requests and checks each result.
// Holds its own model of the queue in a small scoreboard class; depends on stq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_queue_core_tb;

    localparam int N_TIMERS = 16;
    localparam int N_TASKS  = 8;

    // Members from the highest bit down, so that status sits in the lowest bits.
    typedef struct packed {
        logic [stq_pkg::COUNT_W-1:0]  count;
        logic [stq_pkg::EVENT_W-1:0]  ev_out;
        logic [stq_pkg::OWNER_W-1:0]  ev_owner;
        logic                         ev_valid;
        logic [stq_pkg::TIME_W-1:0]   head_alarm;
        logic [stq_pkg::ID_W-1:0]     head_id;
        logic [stq_pkg::STATUS_W-1:0] status;
    } t_result;

    typedef struct packed {
        logic [stq_pkg::FUNC_W-1:0]  func;
        logic [stq_pkg::ID_W-1:0]    id;
        logic [stq_pkg::OWNER_W-1:0] owner;
        logic [stq_pkg::TIME_W-1:0]  alarm;
        logic [stq_pkg::TIME_W-1:0]  period;
        logic                        rep;
        logic                        send;
        logic [stq_pkg::EVENT_W-1:0] ev;
        logic [stq_pkg::TIME_W-1:0]  now;
    } t_request;

    // Scoreboard: a model of the timer queue plus the results still owed by the block.
    class timer_queue_board;
        logic [stq_pkg::ID_W-1:0]    order_q[$];
        logic [stq_pkg::TIME_W-1:0]  alarm_m[N_TIMERS];
        logic [stq_pkg::TIME_W-1:0]  period_m[N_TIMERS];
        logic [stq_pkg::OWNER_W-1:0] owner_m[N_TIMERS];
        logic [stq_pkg::EVENT_W-1:0] event_m[N_TIMERS];
        bit                          rep_m[N_TIMERS];
        bit                          send_m[N_TIMERS];
        bit                          written[N_TIMERS];
        logic [stq_pkg::ID_W-1:0]    free_q[$];
        bit                          is_free[N_TIMERS];
        t_result                     owed_q[$];
        int                          errors;

        function new();
            for (int k = N_TIMERS - 1; k >= N_TASKS; k--) begin
                free_q.push_back(k[stq_pkg::ID_W-1:0]);
                is_free[k] = 1;
            end
        endfunction

        function bit unqueue(logic [stq_pkg::ID_W-1:0] id);
            foreach (order_q[i]) begin
                if (order_q[i] == id) begin
                    order_q.delete(i);
                    return 1;
                end
            end
            return 0;
        endfunction

        // A timer goes after every queued timer with an alarm not greater.
        function void place(logic [stq_pkg::ID_W-1:0] id);
            int pos;
            pos = 0;
            while (pos < order_q.size() && alarm_m[order_q[pos]] <= alarm_m[id]) pos++;
            order_q.insert(pos, id);
        endfunction

        function void release_timer(logic [stq_pkg::ID_W-1:0] id);
            if (id < N_TASKS || is_free[id]) return;
            free_q.push_back(id);
            is_free[id] = 1;
        endfunction

        function void note_request(t_request r);
            t_result e;
            int i;
            e = '0;
            case (r.func)
                stq_pkg::FN_INSERT: begin
                    void'(unqueue(r.id));
                    alarm_m[r.id] = r.alarm;
                    period_m[r.id] = r.period;
                    owner_m[r.id] = r.owner;
                    event_m[r.id] = r.ev;
                    rep_m[r.id] = r.rep;
                    send_m[r.id] = r.send;
                    written[r.id] = 1;
                    place(r.id);
                end
                stq_pkg::FN_POP: begin
                    if (order_q.size() == 0) e.status = stq_pkg::SC_EMPTY;
                    else begin
                        e.head_id = order_q.pop_front();
                        e.head_alarm = alarm_m[e.head_id];
                    end
                end
                stq_pkg::FN_EXPIRE: begin
                    void'(unqueue(r.id));
                    if (rep_m[r.id]) begin
                        alarm_m[r.id] = r.now + period_m[r.id];
                        place(r.id);
                    end else begin
                        release_timer(r.id);
                    end
                    if (r.id >= N_TASKS && send_m[r.id]) begin
                        e.ev_valid = 1;
                        e.ev_owner = owner_m[r.id];
                        e.ev_out = event_m[r.id];
                    end
                end
                stq_pkg::FN_CANCEL: begin
                    if (!unqueue(r.id)) e.status = stq_pkg::SC_NOTQUEUE;
                    else release_timer(r.id);
                end
                stq_pkg::FN_CANOWN: begin
                    i = 0;
                    while (i < order_q.size()) begin
                        if (owner_m[order_q[i]] == r.owner) begin
                            release_timer(order_q[i]);
                            order_q.delete(i);
                        end else i++;
                    end
                end
                stq_pkg::FN_TAKE: begin
                    if (free_q.size() == 0) e.status = stq_pkg::SC_NOFREE;
                    else begin
                        e.head_id = free_q.pop_back();
                        is_free[e.head_id] = 0;
                    end
                end
                default: ;
            endcase
            e.count = stq_pkg::COUNT_W'(order_q.size());
            owed_q.push_back(e);
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (owed_q.size() == 0) begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, got.status); errors++;
            end
            if (got.head_id !== e.head_id) begin
                $error("head_id: expected %0d, actual %0d", e.head_id, got.head_id); errors++;
            end
            if (got.head_alarm !== e.head_alarm) begin
                $error("head_alarm: expected %h, actual %h", e.head_alarm, got.head_alarm);
                errors++;
            end
            if (got.ev_valid !== e.ev_valid) begin
                $error("event_valid: expected %0d, actual %0d", e.ev_valid, got.ev_valid);
                errors++;
            end
            if (got.ev_owner !== e.ev_owner) begin
                $error("event_owner: expected %0d, actual %0d", e.ev_owner, got.ev_owner);
                errors++;
            end
            if (got.ev_out !== e.ev_out) begin
                $error("event_out: expected %h, actual %h", e.ev_out, got.ev_out); errors++;
            end
            if (got.count !== e.count) begin
                $error("queued_count: expected %0d, actual %0d", e.count, got.count); errors++;
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_valid;
    logic                           s_ready;
    logic [stq_pkg::IN_DATA_W-1:0]  s_data;
    logic [stq_pkg::FUNC_W-1:0]     s_user;
    logic                           m_valid;
    logic                           m_ready;
    logic [stq_pkg::OUT_DATA_W-1:0] m_data;

    timer_queue_board board;
    bit               sending_done;

    sorted_timer_queue_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    // Sends one request: optional idle gap, then hold tvalid until accepted.
    // Returns at the falling edge after acceptance with tvalid still high.
    task automatic send_request(t_request r, bit gaps);
        int wait_n;
        wait_n = gaps ? $urandom_range(0, 14) : 0;
        if (wait_n > 0) begin
            s_valid <= 1'b0;
            repeat (wait_n) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= r.func;
        s_data  <= {7'd0, r.now, r.ev, r.send, r.rep, r.period, r.alarm, r.owner, r.id};
        do @(posedge i_clk); while (!s_ready);
        board.note_request(r);
        @(negedge i_clk);
    endtask

    function automatic t_request random_request();
        t_request r;
        int pick;
        r.func   = stq_pkg::FN_INSERT;
        r.id     = $urandom_range(0, N_TIMERS - 1);
        r.owner  = $urandom_range(0, 7);
        r.period = $urandom;
        r.rep    = $urandom_range(0, 1);
        r.send   = $urandom_range(0, 1);
        r.ev     = $urandom;
        r.now    = $urandom;
        // Alarms drawn from a narrow band often, so that ties are common.
        r.alarm  = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 20);
        pick = $urandom_range(0, 99);
        if (pick < 35) r.func = stq_pkg::FN_INSERT;
        else if (pick < 52) r.func = stq_pkg::FN_POP;
        else if (pick < 70) r.func = stq_pkg::FN_EXPIRE;
        else if (pick < 80) r.func = stq_pkg::FN_CANCEL;
        else if (pick < 86) r.func = stq_pkg::FN_CANOWN;
        else if (pick < 97) r.func = stq_pkg::FN_TAKE;
        else r.func = $urandom_range(6, 7);
        // A record is never read before it has been written.
        if (r.func == stq_pkg::FN_EXPIRE && !board.written[r.id]) r.func = stq_pkg::FN_INSERT;
        return r;
    endfunction

    function automatic t_request make_req(logic [stq_pkg::FUNC_W-1:0] f, int id, int owner,
                                          logic [stq_pkg::TIME_W-1:0] alarm,
                                          logic [stq_pkg::TIME_W-1:0] period,
                                          bit rep, bit send, logic [stq_pkg::EVENT_W-1:0] ev,
                                          logic [stq_pkg::TIME_W-1:0] now);
        t_request r;
        r.func = f; r.id = id; r.owner = owner; r.alarm = alarm; r.period = period;
        r.rep = rep; r.send = send; r.ev = ev; r.now = now;
        return r;
    endfunction

    // Receiver side: a random stall before each result, none for about one result in four.
    initial begin
        t_result got;
        int stall;
        m_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (sending_done) stall = 0;
            repeat (stall) @(negedge i_clk);
            @(negedge i_clk);
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
            got = m_data[62:0];
            board.check_result(got);
            @(negedge i_clk);
            m_ready <= 1'b0;
        end
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int guard;
        bit gaps;
        board = new();
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        s_user  = stq_pkg::FN_INSERT;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: empty-queue cases, ties, re-arm, wrap on reload, extremes.
        send_request(make_req(stq_pkg::FN_POP, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_request(make_req(stq_pkg::FN_CANCEL, 3, 0, 0, 0, 0, 0, 0, 0), 0);
        send_request(make_req(stq_pkg::FN_INSERT, 15, 7, '1, '1, 1, 1, '1, '1), 0);
        send_request(make_req(stq_pkg::FN_INSERT, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_request(make_req(stq_pkg::FN_INSERT, 8, 3, 100, 5, 0, 1, 16'h5a5a, 0), 0);
        send_request(make_req(stq_pkg::FN_INSERT, 9, 3, 100, 5, 0, 1, 16'ha5a5, 0), 0);
        send_request(make_req(stq_pkg::FN_INSERT, 8, 3, 100, 7, 1, 0, 16'h0001, 0), 0);
        send_request(make_req(stq_pkg::FN_EXPIRE, 15, 0, 0, 0, 0, 0, 0, 32'hffff_fff0), 0);
        send_request(make_req(stq_pkg::FN_EXPIRE, 9, 0, 0, 0, 0, 0, 0, 5), 0);
        send_request(make_req(stq_pkg::FN_EXPIRE, 0, 0, 0, 0, 0, 0, 0, 5), 0);
        send_request(make_req(stq_pkg::FN_CANCEL, 8, 0, 0, 0, 0, 0, 0, 0), 0);
        send_request(make_req(stq_pkg::FN_CANOWN, 0, 7, 0, 0, 0, 0, 0, 0), 0);
        send_request(make_req(stq_pkg::FN_CANOWN, 0, 2, 0, 0, 0, 0, 0, 0), 0);
        for (int k = 0; k < 9; k++)
            send_request(make_req(stq_pkg::FN_TAKE, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_request(make_req(3'd6, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_request(make_req(3'd7, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        for (int k = 0; k < N_TIMERS; k++)
            send_request(make_req(stq_pkg::FN_INSERT, k, k % 8, 50, 1, 0, 1, k, 0), 0);
        send_request(make_req(stq_pkg::FN_POP, 0, 0, 0, 0, 0, 0, 0, 0), 0);

        // Random part, with gap-free stretches alternating with gappy ones.
        for (int n = 0; n < 1950; n++) begin
            if (n % 200 == 0) gaps = (n % 400 != 0);
            send_request(random_request(), gaps);
        end
        s_valid <= 1'b0;
        sending_done = 1;

        guard = 0;
        while (board.owed_q.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
        if (board.errors == 0 && board.owed_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire
